[rtl/jcse_pkg.sv]
package jcse_pkg;

    // fixed geometry of the scan chain
    localparam int IR_LENGTH = 5;
    localparam int WORD_BITS = 32;

    // command codes
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_SHORT_SCAN = 3'd1;
    localparam logic [2:0] CMD_DATA_WRITE = 3'd2;
    localparam logic [2:0] CMD_WORD_SCAN  = 3'd3;
    localparam logic [2:0] CMD_TMS_WALK   = 3'd4;

    // scan modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_RW    = 2'd2;

    // word scan entry paths
    localparam logic [1:0] ENTRY_NONE  = 2'd0;
    localparam logic [1:0] ENTRY_SHORT = 2'd1;
    localparam logic [1:0] ENTRY_LONG  = 2'd2;

    // word scan exit paths
    localparam logic [1:0] EXIT_STAY  = 2'd0;
    localparam logic [1:0] EXIT_IDLE  = 2'd1;
    localparam logic [1:0] EXIT_PAUSE = 2'd2;
    localparam logic [1:0] EXIT_ONLY  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DATA_INSTR = 2'd0;
    localparam logic [1:0] CFG_CTRL_INSTR = 2'd1;
    localparam logic [1:0] CFG_CTRL_WORD  = 2'd2;

    localparam logic [4:0]  DATA_INSTR_RESET = 5'h09;
    localparam logic [4:0]  CTRL_INSTR_RESET = 5'h0a;
    localparam logic [31:0] CTRL_WORD_RESET  = 32'h8000_c000;

    // tms path patterns, lsb first, with their lengths
    localparam logic [31:0] PAT_IR_ENTRY  = 32'h0000_0003;
    localparam logic [7:0]  LEN_IR_ENTRY  = 8'd4;
    localparam logic [31:0] PAT_IR7_ENTRY = 32'd27;
    localparam logic [7:0]  LEN_IR7_ENTRY = 8'd7;
    localparam logic [31:0] PAT_EXIT      = 32'h0000_0001;
    localparam logic [7:0]  LEN_EXIT      = 8'd2;
    localparam logic [31:0] PAT_DR_ENTRY  = 32'h0000_0001;
    localparam logic [7:0]  LEN_DR_ENTRY  = 8'd3;
    localparam logic [31:0] PAT_DR7_ENTRY = 32'd23;
    localparam logic [7:0]  LEN_DR7_ENTRY = 8'd7;
    localparam logic [31:0] PAT_PAUSE     = 32'h0000_0000;
    localparam logic [7:0]  LEN_PAUSE     = 8'd1;

    localparam logic [3:0] SEG_COUNT_MAX = 4'd12;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  scan_length;
        logic [31:0] scan_data;
        logic [1:0]  scan_mode;
        logic [1:0]  entry_path;
        logic [1:0]  exit_path;
        logic [7:0]  walk_bits;
        logic [3:0]  walk_first;
        logic [7:0]  walk_end;
        logic        tdo;
    } cmd_item_t;

    typedef struct packed {
        logic        tms;
        logic        tdi;
        logic        last_bit;
        logic        read_valid;
        logic [31:0] read_data;
    } rsp_item_t;

    typedef struct packed {
        logic [3:0] scan_length;
        logic [1:0] scan_mode;
        logic [1:0] entry_path;
        logic [1:0] exit_path;
        logic [7:0] walk_bits;
        logic [3:0] walk_first;
        logic [7:0] walk_end;
    } opt_t;

    typedef struct packed {
        logic        is_scan;
        logic [7:0]  len;
        logic [31:0] bits;
        logic        last_tms;
        logic        cap;
        logic        final_seg;
    } seg_t;

endpackage

[rtl/jtag_command_shift_engine.sv]
// channel | direction | handshake            | beat payload
// cmd     | in        | cmd_valid/cmd_stall  | jcse_pkg::cmd_item_t (command fields and tdo)
// rsp     | out       | rsp_valid/rsp_stall  | jcse_pkg::rsp_item_t (tms, tdi, last, read data)
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index (register) and cfg_data
//
// one cmd beat in every clock while cmd_stall is low; each beat that starts a command
// or arrives while busy gives one rsp beat, a single tck cycle, registered (rsp or skid)
// the sequence logic is one pass between the state registers and the rsp register
// a two-entry output (rsp register plus skid) takes one more cmd beat while rsp is stalled
// cmd_stall rises only once the skid entry is full
// reset (asynchronous, rst_n low): engine idle, state and cfg registers at defaults
module jtag_command_shift_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  jcse_pkg::cmd_item_t   cmd_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output jcse_pkg::rsp_item_t   rsp_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import jcse_pkg::*;

    // configuration registers, read live by the data word write
    logic [4:0]  data_instr_reg;
    logic [4:0]  ctrl_instr_reg;
    logic [31:0] ctrl_word_reg;

    // command state
    logic        busy_reg,    busy_next;
    logic [2:0]  active_reg,  active_next;
    logic [3:0]  seg_reg,     seg_next;
    logic [7:0]  bit_reg,     bit_next;
    logic [31:0] shift_reg,   shift_next;
    logic [31:0] capture_reg, capture_next;
    opt_t        opt_reg,     opt_next;

    // output register and skid entry
    logic        out_valid_reg,  out_valid_next;
    rsp_item_t   out_reg,        out_next;
    logic        skid_valid_reg, skid_valid_next;
    rsp_item_t   skid_reg,       skid_next;

    logic        accept;
    logic        start;
    logic        produce;
    logic        out_take;
    logic [2:0]  eff_cmd;
    opt_t        eff_opt;
    opt_t        in_opt;
    logic [31:0] eff_shift;
    logic [3:0]  eff_seg;
    logic [7:0]  eff_bit;
    logic [31:0] eff_capture;
    seg_t        desc;
    logic [8:0]  bit_inc;
    logic        seg_done;
    logic        last;
    logic        in_range;
    rsp_item_t   result;

    // describes segment seg of the active command's tck sequence
    function automatic seg_t seg_desc(
        input logic [2:0]  c,
        input opt_t        o,
        input logic [3:0]  seg,
        input logic [31:0] so,
        input logic [4:0]  di,
        input logic [4:0]  ci,
        input logic [31:0] cw
    );
        seg_t        d;
        logic [3:0]  n;
        logic        has_pre;
        logic [3:0]  p;
        logic        h;
        logic [3:0]  q;
        logic [31:0] data;
        logic        rd_mode;
        d         = '0;
        d.len     = 8'd1;
        data      = (o.scan_mode == MODE_READ) ? 32'd0 : so;
        rd_mode   = (o.scan_mode != MODE_WRITE);
        n         = o.scan_length;
        has_pre   = 1'b0;
        p         = seg;
        h         = 1'b0;
        q         = seg;
        unique case (c)
            CMD_SHORT_SCAN:
            begin
                if (o.scan_length == 4'd0)
                begin
                    n = 4'd1;
                end
                else if (o.scan_length > 4'd8)
                begin
                    n = 4'd8;
                end
                has_pre = (n == 4'd5) || (n == 4'd7);
                p       = has_pre ? seg : seg + 4'd1;
                unique case (p)
                    4'd0:
                    begin
                        d.bits = (n == 4'd5) ? PAT_IR_ENTRY : PAT_IR7_ENTRY;
                        d.len  = (n == 4'd5) ? LEN_IR_ENTRY : LEN_IR7_ENTRY;
                    end
                    4'd1:
                    begin
                        d.is_scan  = 1'b1;
                        d.bits     = {24'd0, data[7:0]};
                        d.len      = {4'd0, n};
                        d.last_tms = 1'b1;
                        d.cap      = rd_mode;
                    end
                    default:
                    begin
                        d.bits      = PAT_EXIT;
                        d.len       = LEN_EXIT;
                        d.final_seg = 1'b1;
                    end
                endcase
            end
            CMD_DATA_WRITE:
            begin
                // two halves: data word, then control word
                h = (seg >= 4'd6);
                q = h ? seg - 4'd6 : seg;
                unique case (q)
                    4'd0:
                    begin
                        d.bits = PAT_IR_ENTRY;
                        d.len  = LEN_IR_ENTRY;
                    end
                    4'd1:
                    begin
                        d.is_scan  = 1'b1;
                        d.bits     = h ? 32'(ci) : 32'(di);
                        d.len      = 8'(IR_LENGTH);
                        d.last_tms = 1'b1;
                    end
                    4'd3:
                    begin
                        d.bits = PAT_DR_ENTRY;
                        d.len  = LEN_DR_ENTRY;
                    end
                    4'd4:
                    begin
                        d.is_scan  = 1'b1;
                        d.bits     = h ? cw : so;
                        d.len      = 8'(WORD_BITS);
                        d.last_tms = 1'b1;
                    end
                    default:
                    begin
                        d.bits      = PAT_EXIT;
                        d.len       = LEN_EXIT;
                        d.final_seg = h && (q == 4'd5);
                    end
                endcase
            end
            CMD_WORD_SCAN:
            begin
                has_pre = (o.entry_path == ENTRY_SHORT) || (o.entry_path == ENTRY_LONG);
                p       = has_pre ? seg : seg + 4'd1;
                unique case (p)
                    4'd0:
                    begin
                        d.bits = (o.entry_path == ENTRY_SHORT) ? PAT_DR_ENTRY : PAT_DR7_ENTRY;
                        d.len  = (o.entry_path == ENTRY_SHORT) ? LEN_DR_ENTRY : LEN_DR7_ENTRY;
                    end
                    4'd1:
                    begin
                        d.is_scan   = 1'b1;
                        d.bits      = data;
                        d.len       = 8'(WORD_BITS);
                        d.last_tms  = (o.exit_path != EXIT_STAY);
                        d.cap       = rd_mode;
                        d.final_seg = (o.exit_path == EXIT_STAY) || (o.exit_path == EXIT_ONLY);
                    end
                    default:
                    begin
                        d.bits      = (o.exit_path == EXIT_IDLE) ? PAT_EXIT : PAT_PAUSE;
                        d.len       = (o.exit_path == EXIT_IDLE) ? LEN_EXIT : LEN_PAUSE;
                        d.final_seg = 1'b1;
                    end
                endcase
            end
            default:
            begin
                // tms walk: one path segment starting at walk_first
                d.bits      = 32'(o.walk_bits >> o.walk_first);
                d.len       = o.walk_end - 8'(o.walk_first);
                d.final_seg = 1'b1;
            end
        endcase
        return d;
    endfunction

    assign cfg_ready = 1'b1;
    assign cmd_stall = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    assign accept   = cmd_valid && !cmd_stall;
    assign out_take = out_valid_reg && !rsp_stall;

    // idle engine starts on any command but tick or a spare code; an empty walk does nothing
    assign start = !busy_reg
        && (cmd_data.cmd >= CMD_SHORT_SCAN) && (cmd_data.cmd <= CMD_TMS_WALK)
        && !((cmd_data.cmd == CMD_TMS_WALK)
             && (cmd_data.walk_end <= {4'd0, cmd_data.walk_first}));
    assign produce = accept && (busy_reg || start);

    always_comb
    begin
        in_opt.scan_length = cmd_data.scan_length;
        in_opt.scan_mode   = cmd_data.scan_mode;
        in_opt.entry_path  = cmd_data.entry_path;
        in_opt.exit_path   = cmd_data.exit_path;
        in_opt.walk_bits   = cmd_data.walk_bits;
        in_opt.walk_first  = cmd_data.walk_first;
        in_opt.walk_end    = cmd_data.walk_end;
    end

    // while busy the command fields are ignored and the latched copy is used
    assign eff_cmd     = busy_reg ? active_reg  : cmd_data.cmd;
    assign eff_opt     = busy_reg ? opt_reg     : in_opt;
    assign eff_shift   = busy_reg ? shift_reg   : cmd_data.scan_data;
    assign eff_seg     = busy_reg ? seg_reg     : 4'd0;
    assign eff_bit     = busy_reg ? bit_reg     : 8'd0;
    assign eff_capture = busy_reg ? capture_reg : 32'd0;

    assign desc = seg_desc(eff_cmd, eff_opt, eff_seg, eff_shift,
                           data_instr_reg, ctrl_instr_reg, ctrl_word_reg);

    assign in_range = (eff_bit < 8'd32);
    assign bit_inc  = {1'b0, eff_bit} + 9'd1;
    assign seg_done = (bit_inc >= {1'b0, desc.len});
    assign last     = seg_done && desc.final_seg;

    // one tck cycle: tms/tdi for this bit, tdo folded into the capture
    always_comb
    begin
        capture_next = eff_capture;
        result       = '0;
        if (desc.is_scan)
        begin
            result.tdi = in_range && desc.bits[eff_bit[4:0]];
            result.tms = (bit_inc == {1'b0, desc.len}) && desc.last_tms;
            if (desc.cap && in_range && cmd_data.tdo)
            begin
                capture_next = eff_capture | (32'd1 << eff_bit[4:0]);
            end
        end
        else
        begin
            result.tms = in_range && desc.bits[eff_bit[4:0]];
        end
        result.last_bit   = last;
        result.read_valid = last
            && ((eff_cmd == CMD_SHORT_SCAN) || (eff_cmd == CMD_WORD_SCAN))
            && (eff_opt.scan_mode != MODE_WRITE);
        result.read_data  = result.read_valid ? capture_next : 32'd0;
    end

    // command state advance
    always_comb
    begin
        busy_next   = busy_reg;
        active_next = active_reg;
        seg_next    = seg_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        opt_next    = opt_reg;
        if (produce)
        begin
            busy_next   = !last;
            active_next = eff_cmd;
            shift_next  = eff_shift;
            opt_next    = eff_opt;
            if (seg_done)
            begin
                bit_next = 8'd0;
                seg_next = last ? 4'd0 : eff_seg + 4'd1;
            end
            else
            begin
                bit_next = bit_inc[7:0];
                seg_next = eff_seg;
            end
        end
    end

    // output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (produce)
            begin
                out_valid_next = 1'b1;
                out_next       = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_instr_reg <= DATA_INSTR_RESET;
            ctrl_instr_reg <= CTRL_INSTR_RESET;
            ctrl_word_reg  <= CTRL_WORD_RESET;
            busy_reg       <= 1'b0;
            active_reg     <= CMD_TICK;
            seg_reg        <= 4'd0;
            bit_reg        <= 8'd0;
            capture_reg    <= 32'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                priority case (cfg_index)
                    CFG_DATA_INSTR: data_instr_reg <= cfg_data[4:0];
                    CFG_CTRL_INSTR: ctrl_instr_reg <= cfg_data[4:0];
                    CFG_CTRL_WORD:  ctrl_word_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            busy_reg       <= busy_next;
            active_reg     <= active_next;
            seg_reg        <= seg_next;
            bit_reg        <= bit_next;
            if (produce)
            begin
                capture_reg <= capture_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        opt_reg   <= opt_next;
        out_reg   <= out_next;
        skid_reg  <= skid_next;
    end

    a_read_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.read_valid |-> rsp_data.last_bit)
        else $error("read data returned before the last bit");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.read_valid |-> (rsp_data.read_data == 32'd0))
        else $error("read data not zero on a plain beat");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(produce && last))
        else $error("engine went idle without a last bit");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with the output register empty");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (seg_reg < SEG_COUNT_MAX))
        else $error("segment index out of range");

endmodule

[tb/tb.sv]
module tb;

    import jcse_pkg::*;

    // spare codes the package leaves unnamed
    localparam logic [2:0] CMD_UNUSED_A = 3'd5;
    localparam logic [2:0] CMD_UNUSED_B = 3'd6;
    localparam logic [2:0] CMD_UNUSED_C = 3'd7;
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam logic [1:0] ENTRY_SPARE  = 2'd3;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;

    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BEATS  = 150;
    localparam int RUN_LIMIT     = 400000;

    // one stretch of tck cycles: a tms path or a shift of data bits
    typedef struct packed {
        logic        is_scan;
        logic [7:0]  len;
        logic [31:0] bits;
        logic        last_tms;
        logic        capt;
    } tck_seg_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    cmd_item_t           cmd_data = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_item_t           rsp_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    // predicted engine state and register copies
    logic                eng_busy = 1'b0;
    logic [2:0]          eng_cmd = '0;
    logic [3:0]          eng_seg = '0;
    logic [7:0]          eng_bit = '0;
    logic [31:0]         eng_shift = '0;
    logic [31:0]         eng_cap = '0;
    opt_t                eng_opt = '0;
    logic [4:0]          reg_data_instr = DATA_INSTR_RESET;
    logic [4:0]          reg_ctrl_instr = CTRL_INSTR_RESET;
    logic [31:0]         reg_ctrl_word = CTRL_WORD_RESET;

    // tck cycles still owed by the engine, oldest first
    rsp_item_t           expected_tck[$];
    int                  tck_items = 0;
    int                  failures = 0;
    int                  cycle_count = 0;

    // shared idling controls
    bit                  quiet = 1'b0;
    bit                  hold_trigger = 1'b0;
    int                  hold_len = 0;

    jtag_command_shift_engine i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tck_seg_t make_seg(input logic is_scan, input logic [7:0] len,
            input logic [31:0] bits, input logic last_tms, input logic capt);
        tck_seg_t s;
        s.is_scan  = is_scan;
        s.len      = len;
        s.bits     = bits;
        s.last_tms = last_tms;
        s.capt     = capt;
        return s;
    endfunction

    // lays out the whole sequence of the latched command and picks the live stretch
    function automatic tck_seg_t current_segment(output int seg_count);
        tck_seg_t    plan [0:15];
        int          k;
        logic [1:0]  mode;
        logic [31:0] data;
        logic        capt;
        logic [3:0]  n;
        logic [7:0]  walk_len;
        for (int j = 0; j < 16; j++)
            plan[j] = '0;
        k    = 0;
        mode = eng_opt.scan_mode;
        data = (mode == MODE_READ) ? 32'd0 : eng_shift;
        capt = (mode != MODE_WRITE);
        case (eng_cmd)
            CMD_SHORT_SCAN:
            begin
                // length 0 behaves as 1, anything past 8 as 8
                n = eng_opt.scan_length;
                if (n == 4'd0)
                    n = 4'd1;
                if (n > 4'd8)
                    n = 4'd8;
                // 5 and 7 bit scans walk into shift-ir first
                if (n == 4'd5)
                begin
                    plan[k] = make_seg(1'b0, 8'd4, 32'h3, 1'b0, 1'b0);
                    k++;
                end
                if (n == 4'd7)
                begin
                    plan[k] = make_seg(1'b0, 8'd7, 32'd27, 1'b0, 1'b0);
                    k++;
                end
                plan[k] = make_seg(1'b1, {4'd0, n}, data & 32'hff, 1'b1, capt);
                k++;
                plan[k] = make_seg(1'b0, 8'd2, 32'h1, 1'b0, 1'b0);
                k++;
            end
            CMD_DATA_WRITE:
            begin
                // ir scan, data dr scan, ir scan, control dr scan; nothing captured
                plan[0]  = make_seg(1'b0, 8'd4, 32'h3, 1'b0, 1'b0);
                plan[1]  = make_seg(1'b1, 8'd5, {27'd0, reg_data_instr}, 1'b1, 1'b0);
                plan[2]  = make_seg(1'b0, 8'd2, 32'h1, 1'b0, 1'b0);
                plan[3]  = make_seg(1'b0, 8'd3, 32'h1, 1'b0, 1'b0);
                plan[4]  = make_seg(1'b1, 8'd32, eng_shift, 1'b1, 1'b0);
                plan[5]  = make_seg(1'b0, 8'd2, 32'h1, 1'b0, 1'b0);
                plan[6]  = make_seg(1'b0, 8'd4, 32'h3, 1'b0, 1'b0);
                plan[7]  = make_seg(1'b1, 8'd5, {27'd0, reg_ctrl_instr}, 1'b1, 1'b0);
                plan[8]  = make_seg(1'b0, 8'd2, 32'h1, 1'b0, 1'b0);
                plan[9]  = make_seg(1'b0, 8'd3, 32'h1, 1'b0, 1'b0);
                plan[10] = make_seg(1'b1, 8'd32, reg_ctrl_word, 1'b1, 1'b0);
                plan[11] = make_seg(1'b0, 8'd2, 32'h1, 1'b0, 1'b0);
                k = 12;
            end
            CMD_WORD_SCAN:
            begin
                // the spare entry code means no entry path
                if (eng_opt.entry_path == ENTRY_SHORT)
                begin
                    plan[k] = make_seg(1'b0, 8'd3, 32'h1, 1'b0, 1'b0);
                    k++;
                end
                else if (eng_opt.entry_path == ENTRY_LONG)
                begin
                    plan[k] = make_seg(1'b0, 8'd7, 32'd23, 1'b0, 1'b0);
                    k++;
                end
                plan[k] = make_seg(1'b1, 8'd32, data, eng_opt.exit_path != EXIT_STAY, capt);
                k++;
                if (eng_opt.exit_path == EXIT_IDLE)
                begin
                    plan[k] = make_seg(1'b0, 8'd2, 32'h1, 1'b0, 1'b0);
                    k++;
                end
                else if (eng_opt.exit_path == EXIT_PAUSE)
                begin
                    plan[k] = make_seg(1'b0, 8'd1, 32'h0, 1'b0, 1'b0);
                    k++;
                end
            end
            default:
            begin
                // tms walk: pattern bits past 7 read as 0
                walk_len = (eng_opt.walk_end > {4'd0, eng_opt.walk_first}) ?
                           eng_opt.walk_end - {4'd0, eng_opt.walk_first} : 8'd0;
                plan[0] = make_seg(1'b0, walk_len,
                                   {24'd0, eng_opt.walk_bits} >> eng_opt.walk_first,
                                   1'b0, 1'b0);
                k = 1;
            end
        endcase
        seg_count = k;
        return plan[eng_seg];
    endfunction

    // advances the predicted engine by one accepted beat and queues its tck cycle
    function automatic void step_engine(input cmd_item_t it);
        tck_seg_t  cur;
        int        seg_count;
        int        i;
        rsp_item_t r;
        if (!eng_busy)
        begin
            // idle: only a real, non-empty command starts the engine
            if (it.cmd < CMD_SHORT_SCAN || it.cmd > CMD_TMS_WALK)
                return;
            if (it.cmd == CMD_TMS_WALK && it.walk_end <= {4'd0, it.walk_first})
                return;
            eng_busy              = 1'b1;
            eng_cmd               = it.cmd;
            eng_seg               = '0;
            eng_bit               = '0;
            eng_cap               = '0;
            eng_shift             = it.scan_data;
            eng_opt.scan_length   = it.scan_length;
            eng_opt.scan_mode     = it.scan_mode;
            eng_opt.entry_path    = it.entry_path;
            eng_opt.exit_path     = it.exit_path;
            eng_opt.walk_bits     = it.walk_bits;
            eng_opt.walk_first    = it.walk_first;
            eng_opt.walk_end      = it.walk_end;
        end
        cur = current_segment(seg_count);
        i   = int'(eng_bit);
        r   = '0;
        if (cur.is_scan)
        begin
            r.tdi = (i < 32) ? cur.bits[i] : 1'b0;
            r.tms = (i + 1 == int'(cur.len)) ? cur.last_tms : 1'b0;
            if (cur.capt && i < 32 && it.tdo)
                eng_cap[i] = 1'b1;
        end
        else
        begin
            r.tms = (i < 32) ? cur.bits[i] : 1'b0;
        end
        if (i + 1 >= int'(cur.len))
        begin
            eng_bit = '0;
            eng_seg = eng_seg + 4'd1;
            if (int'(eng_seg) >= seg_count)
            begin
                r.last_bit = 1'b1;
                eng_busy   = 1'b0;
                eng_seg    = '0;
                if ((eng_cmd == CMD_SHORT_SCAN || eng_cmd == CMD_WORD_SCAN) &&
                    eng_opt.scan_mode != MODE_WRITE)
                begin
                    r.read_valid = 1'b1;
                    r.read_data  = eng_cap;
                end
            end
        end
        else
        begin
            eng_bit = eng_bit + 8'd1;
        end
        expected_tck.push_back(r);
        tck_items++;
    endfunction

    // every bit random, tdo included
    function automatic cmd_item_t noise_beat();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(cmd_item_t)-1:0];
    endfunction

    function automatic cmd_item_t make_command(input logic [2:0] code,
            input logic [3:0] len, input logic [31:0] data, input logic [1:0] mode,
            input logic [1:0] entry, input logic [1:0] leave, input logic [7:0] wbits,
            input logic [3:0] wfirst, input logic [7:0] wend);
        cmd_item_t b;
        b             = noise_beat();
        b.cmd         = code;
        b.scan_length = len;
        b.scan_data   = data;
        b.scan_mode   = mode;
        b.entry_path  = entry;
        b.exit_path   = leave;
        b.walk_bits   = wbits;
        b.walk_first  = wfirst;
        b.walk_end    = wend;
        return b;
    endfunction

    function automatic cmd_item_t random_command();
        cmd_item_t   b;
        int          pick;
        logic [31:0] span;
        b    = noise_beat();
        pick = $urandom_range(99);
        if (pick < 35)
            b.cmd = CMD_SHORT_SCAN;
        else if (pick < 65)
            b.cmd = CMD_WORD_SCAN;
        else if (pick < 90)
            b.cmd = CMD_TMS_WALK;
        else
            b.cmd = CMD_DATA_WRITE;
        // walks kept mostly short, a few keep a fully random end
        span = $urandom_range(12, 1);
        if (b.cmd == CMD_TMS_WALK && $urandom_range(9) != 0)
            b.walk_end = {4'd0, b.walk_first} + span[7:0];
        return b;
    endfunction

    // a beat the idle engine throws away: tick, spare code or empty walk
    function automatic cmd_item_t idle_noise();
        cmd_item_t b;
        b = noise_beat();
        if (b.cmd == CMD_SHORT_SCAN || b.cmd == CMD_DATA_WRITE || b.cmd == CMD_WORD_SCAN)
            b.cmd = CMD_TICK;
        if (b.cmd == CMD_TMS_WALK)
            b.walk_end = {4'd0, b.walk_first} - {7'd0, b.walk_first[0]};
        return b;
    endfunction

    // offers one cmd beat, with random gaps unless quiet, and predicts it once taken
    task automatic send_beat(input cmd_item_t item);
        if (!quiet)
            while ($urandom_range(99) < 36)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
            end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        step_engine(item);
    endtask

    // one command and the random beats that clock it out, noise in the ignored fields
    task automatic run_command(input cmd_item_t item);
        send_beat(item);
        while (eng_busy)
            send_beat(noise_beat());
    endtask

    // sender pauses until every owed tck cycle is back, then idles for SETTLE_CYCLES
    task automatic settle();
        cmd_valid <= 1'b0;
        while (expected_tck.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        if (!quiet)
            while ($urandom_range(99) < 36)
            begin
                cfg_valid <= 1'b0;
                @(posedge clk);
            end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DATA_INSTR: reg_data_instr = value[4:0];
            CFG_CTRL_INSTR: reg_ctrl_instr = value[4:0];
            CFG_CTRL_WORD:  reg_ctrl_word  = value;
            default:        ;
        endcase
    endtask

    // registers only change with the engine idle and the output drained
    task automatic load_settings(input logic [31:0] di, input logic [31:0] ci,
            input logic [31:0] cw, input bit with_unused);
        settle();
        write_register(CFG_DATA_INSTR, di);
        write_register(CFG_CTRL_INSTR, ci);
        write_register(CFG_CTRL_WORD, cw);
        if (with_unused)
            write_register(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_short_scans();
        run_command(make_command(CMD_SHORT_SCAN, 4'd1, 32'hffff_ffff, MODE_RW,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        run_command(make_command(CMD_SHORT_SCAN, 4'd5, 32'h0000_0015, MODE_READ,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        run_command(make_command(CMD_SHORT_SCAN, 4'd7, 32'h0000_006a, MODE_WRITE,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        run_command(make_command(CMD_SHORT_SCAN, 4'd8, 32'h1234_56a5, MODE_RW,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        // length 0 and the spare mode
        run_command(make_command(CMD_SHORT_SCAN, 4'd0, 32'h0000_0001, MODE_SPARE,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        // length past 8, upper data bits must not leak out
        run_command(make_command(CMD_SHORT_SCAN, 4'd15, 32'hffff_ff00, MODE_RW,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
    endtask

    task automatic test_data_write_defaults();
        run_command(make_command(CMD_DATA_WRITE, 4'd0, 32'hffff_ffff, MODE_RW,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        run_command(make_command(CMD_DATA_WRITE, 4'd15, 32'h0000_0000, MODE_WRITE,
                                 ENTRY_SPARE, EXIT_ONLY, 8'hff, 4'd15, 8'hff));
    endtask

    task automatic test_word_scans();
        run_command(make_command(CMD_WORD_SCAN, 4'd0, 32'hdead_beef, MODE_RW,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        run_command(make_command(CMD_WORD_SCAN, 4'd0, 32'hffff_ffff, MODE_READ,
                                 ENTRY_SHORT, EXIT_IDLE, 8'd0, 4'd0, 8'd0));
        run_command(make_command(CMD_WORD_SCAN, 4'd0, 32'h8000_0001, MODE_WRITE,
                                 ENTRY_LONG, EXIT_PAUSE, 8'd0, 4'd0, 8'd0));
        // spare entry code acts as none, spare mode as read-write
        run_command(make_command(CMD_WORD_SCAN, 4'd0, 32'h0000_0000, MODE_SPARE,
                                 ENTRY_SPARE, EXIT_ONLY, 8'd0, 4'd0, 8'd0));
    endtask

    task automatic test_tms_walks();
        run_command(make_command(CMD_TMS_WALK, 4'd0, 32'd0, MODE_WRITE,
                                 ENTRY_NONE, EXIT_STAY, 8'hff, 4'd0, 8'd8));
        // run far past the pattern, the tail is all tms 0
        run_command(make_command(CMD_TMS_WALK, 4'd0, 32'd0, MODE_WRITE,
                                 ENTRY_NONE, EXIT_STAY, 8'ha5, 4'd3, 8'd255));
        // start beyond the pattern, a walk of length one
        run_command(make_command(CMD_TMS_WALK, 4'd0, 32'd0, MODE_WRITE,
                                 ENTRY_NONE, EXIT_STAY, 8'hff, 4'd15, 8'd16));
    endtask

    // beats that must give nothing at all while idle
    task automatic test_idle_noise();
        send_beat(make_command(CMD_TICK, 4'd8, 32'hffff_ffff, MODE_RW,
                               ENTRY_LONG, EXIT_IDLE, 8'hff, 4'd0, 8'd8));
        send_beat(make_command(CMD_UNUSED_A, 4'd8, 32'hffff_ffff, MODE_RW,
                               ENTRY_LONG, EXIT_IDLE, 8'hff, 4'd0, 8'd8));
        send_beat(make_command(CMD_UNUSED_B, 4'd1, 32'h0, MODE_READ,
                               ENTRY_NONE, EXIT_STAY, 8'hff, 4'd0, 8'd8));
        send_beat(make_command(CMD_UNUSED_C, 4'd5, 32'h1, MODE_WRITE,
                               ENTRY_SHORT, EXIT_PAUSE, 8'hff, 4'd0, 8'd8));
        // empty walks: end equal to and below the first index
        send_beat(make_command(CMD_TMS_WALK, 4'd0, 32'd0, MODE_WRITE,
                               ENTRY_NONE, EXIT_STAY, 8'hff, 4'd4, 8'd4));
        send_beat(make_command(CMD_TMS_WALK, 4'd0, 32'd0, MODE_WRITE,
                               ENTRY_NONE, EXIT_STAY, 8'hff, 4'd15, 8'd0));
        // and the engine still starts cleanly afterwards
        run_command(make_command(CMD_SHORT_SCAN, 4'd3, 32'h5, MODE_RW,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
    endtask

    task automatic test_config_extremes();
        load_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        run_command(make_command(CMD_DATA_WRITE, 4'd0, 32'ha5a5_5a5a, MODE_WRITE,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        load_settings(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        run_command(make_command(CMD_DATA_WRITE, 4'd0, 32'h0000_0000, MODE_RW,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
        load_settings($urandom, $urandom, $urandom, 1'b1);
        run_command(make_command(CMD_DATA_WRITE, 4'd0, $urandom, MODE_READ,
                                 ENTRY_NONE, EXIT_STAY, 8'd0, 4'd0, 8'd0));
    endtask

    // receiver holds off while the sender keeps pushing, so cmd_stall must rise
    task automatic test_back_pressure();
        settle();
        quiet        = 1'b1;
        hold_len     = 60;
        hold_trigger = ~hold_trigger;
        run_command(make_command(CMD_WORD_SCAN, 4'd0, $urandom, MODE_RW,
                                 ENTRY_LONG, EXIT_IDLE, 8'd0, 4'd0, 8'd0));
        settle();
        quiet = 1'b0;
    endtask

    // back-to-back beats on both sides
    task automatic test_no_idling();
        quiet = 1'b1;
        repeat (8)
            run_command(random_command());
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int start;
        int next_cfg;
        start    = tck_items;
        next_cfg = 50;
        while (tck_items - start < RANDOM_BEATS)
        begin
            if (tck_items - start >= next_cfg)
            begin
                next_cfg += 50;
                load_settings($urandom, $urandom, $urandom, $urandom_range(1) == 1);
            end
            if ($urandom_range(9) == 0)
                send_beat(idle_noise());
            else
                run_command(random_command());
        end
    endtask

    // receiver: random stalls, quiet stretches and one long hold-off on request
    initial
    begin
        bit hold_seen;
        int hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99) < 36);
        end
    end

    // every rsp beat taken is checked against the oldest owed tck cycle
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_tck.size() == 0)
            begin
                $error("rsp beat with nothing owed: tms %0b tdi %0b", rsp_data.tms,
                       rsp_data.tdi);
                failures++;
            end
            else
            begin
                want = expected_tck.pop_front();
                if (rsp_data.tms !== want.tms)
                begin
                    $error("tms expected %0b actual %0b", want.tms, rsp_data.tms);
                    failures++;
                end
                if (rsp_data.tdi !== want.tdi)
                begin
                    $error("tdi expected %0b actual %0b", want.tdi, rsp_data.tdi);
                    failures++;
                end
                if (rsp_data.last_bit !== want.last_bit)
                begin
                    $error("last_bit expected %0b actual %0b", want.last_bit,
                           rsp_data.last_bit);
                    failures++;
                end
                if (rsp_data.read_valid !== want.read_valid)
                begin
                    $error("read_valid expected %0b actual %0b", want.read_valid,
                           rsp_data.read_valid);
                    failures++;
                end
                if (rsp_data.read_data !== want.read_data)
                begin
                    $error("read_data expected %08h actual %08h", want.read_data,
                           rsp_data.read_data);
                    failures++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("jtag_command_shift_engine test failed");
        $finish;
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_scans();
        test_data_write_defaults();
        test_word_scans();
        test_tms_walks();
        test_idle_noise();
        test_config_extremes();
        test_back_pressure();
        test_no_idling();
        test_random_traffic();
        settle();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (failures == 0 && expected_tck.size() == 0)
            $display("jtag_command_shift_engine test passed");
        else
            $display("jtag_command_shift_engine test failed");
        $finish;
    end

endmodule
